### design/ltc_pkg.sv
package ltc_pkg;

  typedef enum logic [1:0] {
    MODE_NORMAL,
    MODE_VERBATIM,
    MODE_AFTER1,
    MODE_AFTER2
  } mode_t;

  typedef enum logic [1:0] {
    PEND_NONE,
    PEND_J,
    PEND_H
  } pend_t;

  localparam logic       REQ_BYTE     = 1'b0;
  localparam logic       REQ_FLUSH    = 1'b1;

  localparam logic       REG_ESCAPES  = 1'b0;
  localparam logic       REG_ENCODING = 1'b1;

  localparam logic [1:0] ENC_UTF8     = 2'd0;
  localparam logic [1:0] ENC_ISO      = 2'd1;
  localparam logic [1:0] ENC_KOI8     = 2'd2;
  localparam logic [1:0] ENC_RESET    = ENC_KOI8;

  localparam logic [7:0] SWITCH_BYTE  = 8'h3B;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  // code points at 0x400 and up are letters, below that raw bytes
  typedef logic [10:0] code_t;

  typedef struct packed {
    logic  vld;
    code_t code;
  } sym_t;

  typedef struct packed {
    logic       two;
    logic [7:0] b0;
    logic [7:0] b1;
  } enc_t;

  // output bytes of one request, bytes[0] leaves first
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      cnt;
  } burst_t;

  localparam logic [7:0] KOI8_UPPER [32] = '{
    8'hE1, 8'hE2, 8'hF7, 8'hE7, 8'hE4, 8'hE5, 8'hF6, 8'hFA,
    8'hE9, 8'hEA, 8'hEB, 8'hEC, 8'hED, 8'hEE, 8'hEF, 8'hF0,
    8'hF2, 8'hF3, 8'hF4, 8'hF5, 8'hE6, 8'hE8, 8'hE3, 8'hFE,
    8'hFB, 8'hFD, 8'hFF, 8'hF9, 8'hF8, 8'hFC, 8'hE0, 8'hF1
  };

  function automatic logic is_upper(input logic [7:0] c);
    return (c >= 8'h41) && (c <= 8'h5A);
  endfunction

  function automatic logic is_alpha_span(input logic [7:0] c);
    return (c >= 8'h41) && (c <= 8'h7A);
  endfunction

  function automatic sym_t single_letter(input logic [7:0] c);
    logic [7:0] f;
    sym_t       s;
    f = c | 8'h20;
    s.vld = 1'b1;
    s.code = '0;
    unique case (f)
      8'h61: s.code = 11'h430;  // a
      8'h62: s.code = 11'h431;  // b
      8'h76: s.code = 11'h432;  // v
      8'h67: s.code = 11'h433;  // g
      8'h64: s.code = 11'h434;  // d
      8'h69: s.code = 11'h438;  // i
      8'h6C: s.code = 11'h43B;  // l
      8'h6D: s.code = 11'h43C;  // m
      8'h6E: s.code = 11'h43D;  // n
      8'h6F: s.code = 11'h43E;  // o
      8'h70: s.code = 11'h43F;  // p
      8'h72: s.code = 11'h440;  // r
      8'h74: s.code = 11'h442;  // t
      8'h75: s.code = 11'h443;  // u
      8'h66: s.code = 11'h444;  // f
      8'h68: s.code = 11'h445;  // h
      8'h78: s.code = 11'h445;  // x
      8'h77: s.code = 11'h449;  // w
      8'h79: s.code = 11'h44B;  // y
      8'h71: s.code = 11'h44F;  // q
      default: s.vld = 1'b0;
    endcase
    if (!is_alpha_span(c)) s.vld = 1'b0;
    if (is_upper(c)) s.code = s.code - 11'h020;
    return s;
  endfunction

  function automatic logic is_h_class(input logic [7:0] c);
    logic [7:0] f;
    f = c | 8'h20;
    return is_alpha_span(c) &&
           (f == 8'h63 || f == 8'h73 || f == 8'h65 || f == 8'h6B || f == 8'h7A);
  endfunction

  function automatic code_t h_letter(input logic [7:0] c, input logic with_h);
    logic [7:0] f;
    code_t      v;
    f = c | 8'h20;
    unique case (f)
      8'h63: v = with_h ? 11'h447 : 11'h446;  // c
      8'h73: v = with_h ? 11'h448 : 11'h441;  // s
      8'h65: v = with_h ? 11'h44D : 11'h435;  // e
      8'h6B: v = with_h ? 11'h445 : 11'h43A;  // k
      8'h7A: v = with_h ? 11'h436 : 11'h437;  // z
      default: v = {3'b000, c};
    endcase
    if (v[10] && is_upper(c)) v = v - 11'h020;
    return v;
  endfunction

  function automatic code_t j_alone(input logic [7:0] prev);
    return (prev == 8'h4A) ? 11'h419 : 11'h439;
  endfunction

  function automatic sym_t j_join(input logic [7:0] c, input logic up);
    sym_t s;
    s.vld = 1'b1;
    s.code = '0;
    unique case (c)
      8'h41: s.code = 11'h42F;
      8'h4F: s.code = 11'h401;
      8'h55: s.code = 11'h42E;
      8'h48: s.code = 11'h419;
      8'h61: s.code = up ? 11'h42F : 11'h44F;
      8'h6F: s.code = up ? 11'h401 : 11'h451;
      8'h75: s.code = up ? 11'h42E : 11'h44E;
      8'h68: s.code = up ? 11'h419 : 11'h439;
      8'h27: s.code = 11'h42C;  // apostrophe
      8'h60: s.code = 11'h42A;  // backtick
      default: s.vld = 1'b0;
    endcase
    return s;
  endfunction

  function automatic enc_t enc_code(input code_t code, input logic [1:0] enc);
    enc_t e;
    e.two = 1'b0;
    e.b0  = code[7:0];
    e.b1  = '0;
    if (code[10]) begin
      unique case (enc)
        ENC_UTF8: begin
          e.two = 1'b1;
          e.b0  = {3'b110, code[10:6]};
          e.b1  = {2'b10, code[5:0]};
        end
        ENC_ISO: e.b0 = 8'(code - 11'h360);
        ENC_KOI8: begin
          if (code == 11'h401) e.b0 = 8'hB3;
          else if (code == 11'h451) e.b0 = 8'hA3;
          else if (code >= 11'h410 && code <= 11'h42F)
            e.b0 = KOI8_UPPER[5'(code - 11'h410)];
          else if (code >= 11'h430 && code <= 11'h44F)
            e.b0 = KOI8_UPPER[5'(code - 11'h430)] - 8'h20;
          else e.b0 = code[7:0];
        end
        default: e.b0 = code[7:0];
      endcase
    end
    return e;
  endfunction

endpackage

### design/ltc_front.sv
module ltc_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            acc,
  input  logic            req_type,
  input  logic [7:0]      in_byte,
  input  logic            esc_en,
  input  logic [1:0]      enc,
  output logic            push,
  output ltc_pkg::burst_t burst
);
  import ltc_pkg::*;

  mode_t      mode_r, mode_nxt;
  pend_t      pend_r, pend_nxt;
  logic       rv_r, rv_nxt;
  logic [7:0] prev_r, prev_nxt;

  sym_t  lead, fl, rs, s0, s1, jj, sl;
  enc_t  e0, e1;
  mode_t em;
  logic  run, semi;
  logic [2:0] n0, n1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NORMAL;
      pend_r <= PEND_NONE;
      rv_r   <= 1'b0;
      prev_r <= '0;
    end else if (acc) begin
      mode_r <= mode_nxt;
      pend_r <= pend_nxt;
      rv_r   <= rv_nxt;
      prev_r <= prev_nxt;
    end
  end

  always_comb begin
    lead     = '0;
    fl       = '0;
    rs       = '0;
    run      = 1'b0;
    em       = mode_r;
    mode_nxt = mode_r;
    pend_nxt = pend_r;
    rv_nxt   = rv_r;
    prev_nxt = prev_r;
    semi     = (in_byte == SWITCH_BYTE);
    jj       = j_join(in_byte, prev_r == 8'h4A);
    sl       = single_letter(in_byte);

    if (req_type == REQ_FLUSH) begin
      if (mode_r == MODE_NORMAL) begin
        if (pend_r == PEND_J) fl = '{vld: 1'b1, code: j_alone(prev_r)};
        else if (pend_r == PEND_H) fl = '{vld: 1'b1, code: h_letter(prev_r, 1'b0)};
      end else if (mode_r == MODE_AFTER1) begin
        lead = '{vld: 1'b1, code: {3'b000, SWITCH_BYTE}};
      end
      mode_nxt = MODE_NORMAL;
      pend_nxt = PEND_NONE;
      rv_nxt   = 1'b0;
      prev_nxt = '0;
    end else begin
      prev_nxt = in_byte;
      run      = 1'b1;
      unique case (mode_r)
        MODE_NORMAL, MODE_VERBATIM: em = mode_r;
        MODE_AFTER1: begin
          if (semi) begin
            mode_nxt = MODE_AFTER2;
            run      = 1'b0;
          end else begin
            // lone semicolon goes out, byte is then handled in the mode we left
            lead   = '{vld: 1'b1, code: {3'b000, SWITCH_BYTE}};
            em     = rv_r ? MODE_VERBATIM : MODE_NORMAL;
            rv_nxt = 1'b0;
          end
        end
        MODE_AFTER2: begin
          if (semi) begin
            lead     = '{vld: 1'b1, code: {3'b000, SWITCH_BYTE}};
            rs       = '{vld: 1'b1, code: {3'b000, SWITCH_BYTE}};
            mode_nxt = rv_r ? MODE_VERBATIM : MODE_NORMAL;
            rv_nxt   = 1'b0;
            run      = 1'b0;
          end else begin
            // double semicolon toggles the verbatim span
            em     = rv_r ? MODE_NORMAL : MODE_VERBATIM;
            rv_nxt = 1'b0;
          end
        end
        default: em = mode_r;
      endcase

      if (run) begin
        if (em == MODE_VERBATIM) begin
          if (semi) begin
            rv_nxt   = 1'b1;
            mode_nxt = MODE_AFTER1;
          end else begin
            rs       = '{vld: 1'b1, code: {3'b000, in_byte}};
            mode_nxt = MODE_VERBATIM;
          end
        end else if (esc_en && semi) begin
          if (pend_r == PEND_J) fl = '{vld: 1'b1, code: j_alone(prev_r)};
          else if (pend_r == PEND_H) fl = '{vld: 1'b1, code: h_letter(prev_r, 1'b0)};
          pend_nxt = PEND_NONE;
          rv_nxt   = 1'b0;
          mode_nxt = MODE_AFTER1;
        end else begin
          mode_nxt = MODE_NORMAL;
          pend_nxt = PEND_NONE;
          if (pend_r == PEND_J) begin
            if (jj.vld) rs = jj;
            else fl = '{vld: 1'b1, code: j_alone(prev_r)};
          end else if (pend_r == PEND_H) begin
            if (in_byte == 8'h68 || in_byte == 8'h48)
              rs = '{vld: 1'b1, code: h_letter(prev_r, 1'b1)};
            else fl = '{vld: 1'b1, code: h_letter(prev_r, 1'b0)};
          end
          if (!rs.vld) begin
            if (in_byte == 8'h27) rs = '{vld: 1'b1, code: 11'h44C};
            else if (in_byte == 8'h60) rs = '{vld: 1'b1, code: 11'h44A};
            else if (in_byte == 8'h6A || in_byte == 8'h4A) pend_nxt = PEND_J;
            else if (is_h_class(in_byte)) pend_nxt = PEND_H;
            else if (sl.vld) rs = sl;
            else rs = '{vld: 1'b1, code: {3'b000, in_byte}};
          end
        end
      end
    end

    // at most two of lead, fl, rs are set; keep their order
    s0 = lead.vld ? lead : (fl.vld ? fl : rs);
    s1 = lead.vld ? (fl.vld ? fl : rs) : (fl.vld ? rs : '0);
    e0 = enc_code(s0.code, enc);
    e1 = enc_code(s1.code, enc);
    n0 = s0.vld ? (e0.two ? 3'd2 : 3'd1) : 3'd0;
    n1 = s1.vld ? (e1.two ? 3'd2 : 3'd1) : 3'd0;

    burst.bytes[0] = e0.b0;
    burst.bytes[1] = e0.two ? e0.b1 : e1.b0;
    burst.bytes[2] = e0.two ? e1.b0 : e1.b1;
    burst.bytes[3] = e1.b1;
    burst.cnt      = n0 + n1;
    push           = acc && (burst.cnt != 3'd0);
  end

endmodule

### design/ltc_queue.sv
module ltc_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  ltc_pkg::burst_t wr_data,
  input  logic            pop,
  output ltc_pkg::burst_t head,
  output logic            full,
  output logic            empty
);
  import ltc_pkg::*;

  burst_t            mem_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, rp_r;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_data;
  end

endmodule

### design/ltc_back.sv
module ltc_back (
  input  logic            clk,
  input  logic            rst_n,
  input  ltc_pkg::burst_t head,
  input  logic            empty,
  output logic            pop,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [7:0]      out_tdata,
  output logic            out_tlast
);
  import ltc_pkg::*;

  logic [1:0] idx_r, idx_nxt;
  logic       vld_r, vld_nxt;
  logic [7:0] data_r;
  logic       last_r;
  logic       load, last;

  always_comb begin
    load    = !empty && (!vld_r || out_tready);
    last    = (({1'b0, idx_r} + 3'd1) == head.cnt);
    pop     = load && last;
    idx_nxt = idx_r;
    vld_nxt = vld_r;
    if (load) begin
      idx_nxt = last ? 2'd0 : idx_r + 2'd1;
      vld_nxt = 1'b1;
    end else if (out_tready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      vld_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= head.bytes[idx_r];
      last_r <= last;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = data_r;
  assign out_tlast  = last_r;

endmodule

### design/latin_to_cyrillic_transliterator.sv
// Latin text in, Russian Cyrillic bytes out.
// in_* stream: one request per accepted beat. in_tuser says what it is (0 text
// byte in in_tdata, 1 end of stream flush). out_* stream: one output byte per
// beat, out_tlast marks the final byte caused by a request. A request that
// makes no output (a held j or h-candidate, a semicolon run) gives no beat.
// cfg_* APB port: register 0 at 0x0 enables semicolon escapes, register 1 at
// 0x4 selects the encoding (0 UTF-8, 1 ISO-8859-5, 2 KOI8-R); write only
// while the stream is idle.
// A request is decoded and written into the burst queue, then its first byte
// is loaded from the queue head into the output register behind out_tvalid.
// The output register sends one byte a cycle while out_tready is high; a
// request has 1 to 4 output bytes (two for a UTF-8 letter). The front
// decodes one request a cycle into a two-entry burst queue; in_tready drops
// only while that queue is full.
// Reset (synchronous, rst_n low) clears the translation state, the queue and
// the output register and sets the registers to their defaults. When the
// receiver holds out_tready low, the output beat holds and the queue fills,
// then input stalls.
module latin_to_cyrillic_transliterator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // [7:0] in_byte
  input  logic        in_tuser,     // [0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,    // [7:0] out_byte
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import ltc_pkg::*;

  logic       esc_r;
  logic [1:0] enc_r;
  logic       cfg_wr;
  logic       acc, push, pop, full, empty;
  burst_t     burst, head;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_ENCODING) ? {30'b0, enc_r} : {31'b0, esc_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r <= 1'b0;
      enc_r <= ENC_RESET;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_ESCAPES) esc_r <= cfg_pwdata[0];
      else enc_r <= cfg_pwdata[1:0];
    end
  end

  assign in_tready = !full;
  assign acc       = in_tvalid && in_tready;

  ltc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .req_type (in_tuser),
    .in_byte  (in_tdata),
    .esc_en   (esc_r),
    .enc      (enc_r),
    .push     (push),
    .burst    (burst)
  );

  ltc_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (burst),
    .pop     (pop),
    .head    (head),
    .full    (full),
    .empty   (empty)
  );

  ltc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .empty      (empty),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

### design/ltc_checker.sv
module ltc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [7:0]  in_tdata,
  input logic        in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata,
  input logic        out_tlast,
  input logic        cfg_psel,
  input logic        cfg_penable,
  input logic        cfg_pwrite,
  input logic [2:0]  cfg_paddr,
  input logic [31:0] cfg_pwdata,
  input logic [31:0] cfg_prdata,
  input logic        cfg_pready
);

  // a stalled output beat stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("output beat changed while stalled");

  // a waiting input request is held by the sender
  a_in_stable: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata) && $stable(in_tuser))
    else $error("input request changed while waiting");

  // reset empties the output register and the burst queue
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("reset did not clear the stream side");

  // register 0 reads back what was written
  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && !cfg_paddr[2]
    |=> cfg_paddr[2] || (cfg_prdata[0] == $past(cfg_pwdata[0])))
    else $error("escape register readback mismatch");

endmodule

bind latin_to_cyrillic_transliterator ltc_checker u_ltc_checker (.*);

### verif/latin_to_cyrillic_transliterator_tb.sv
`timescale 1ns / 1ps

module latin_to_cyrillic_transliterator_tb;
  import ltc_pkg::*;

  localparam int CYCLE_LIMIT   = 300000;
  localparam int SETTLE_CYCLES = 8;
  localparam int NOT_LETTER    = -1;
  localparam int PHASE_REQS    = 50;

  localparam logic [1:0] ENC_SPARE = 2'd3;
  localparam logic [7:0] CH_APOS   = 8'h27;
  localparam logic [7:0] CH_GRAVE  = 8'h60;

  // koi8-r bytes of the capitals in alphabet order, entry 0 in the low byte
  localparam logic [255:0] KOI8_CAPS_ROW =
    256'hF1E0FCF8F9FFFDFB_FEE3E8E6F5F4F3F2_F0EFEEEDECEBEAE9_FAF6E5E4E7F7E2E1;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
  } out_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;     // [7:0] in_byte
  logic        in_tuser = REQ_BYTE;  // [0] req_type
  logic        out_tvalid;
  logic        out_tready = 1'b1;
  logic [7:0]  out_tdata;            // [7:0] out_byte
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = 3'd0;
  logic [31:0] cfg_pwdata = 32'd0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // predictor state and its copy of the registers
  mode_t      tl_mode;
  pend_t      tl_pend;
  logic       tl_ret_verb;
  logic [7:0] tl_prev;
  logic       tl_esc;
  logic [1:0] tl_enc;

  logic [7:0] req_bytes[$];
  out_beat_t  cyr_bytes_q[$];
  out_beat_t  head_beat;

  bit    no_idle = 1'b0;
  int    stall_left = 0;
  int    stall_draw;
  int    n_cycles = 0;
  int    n_errs = 0;
  int    n_reqs = 0;
  int    n_flushes = 0;
  int    n_beats = 0;
  string letter_pool = "abvgdeziklmnoprstufhxcwyqjABVGDEZIKLMNOPRSTUFHXCWYQJ";

  latin_to_cyrillic_transliterator u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic void put_byte(input logic [7:0] b);
    if (req_bytes.size() < 4) req_bytes.push_back(b);
  endfunction

  // below 0x400 a raw byte, else a letter code point
  function automatic void put_code(input int code);
    int         tmp;
    logic [7:0] kb;
    if (code < 'h400) begin
      put_byte(code[7:0]);
      return;
    end
    case (tl_enc)
      ENC_UTF8: begin
        tmp = code >> 6;
        put_byte(8'hC0 | tmp[7:0]);
        put_byte(8'h80 | {2'b00, code[5:0]});
      end
      ENC_ISO: begin
        tmp = code - 'h360;
        put_byte(tmp[7:0]);
      end
      ENC_KOI8: begin
        if (code == 'h401) put_byte(8'hB3);
        else if (code == 'h451) put_byte(8'hA3);
        else if (code >= 'h410 && code <= 'h42F) put_byte(KOI8_CAPS_ROW[(code - 'h410) * 8 +: 8]);
        else if (code >= 'h430 && code <= 'h44F) begin
          kb = KOI8_CAPS_ROW[(code - 'h430) * 8 +: 8];
          put_byte(kb - 8'h20);
        end else put_byte(code[7:0]);
      end
      default: put_byte(code[7:0]);
    endcase
  endfunction

  function automatic bit is_caps(input logic [7:0] c);
    return c >= "A" && c <= "Z";
  endfunction

  function automatic int plain_letter(input logic [7:0] f);
    case (f)
      "a": return 'h430;
      "b": return 'h431;
      "v": return 'h432;
      "g": return 'h433;
      "d": return 'h434;
      "i": return 'h438;
      "l": return 'h43B;
      "m": return 'h43C;
      "n": return 'h43D;
      "o": return 'h43E;
      "p": return 'h43F;
      "r": return 'h440;
      "t": return 'h442;
      "u": return 'h443;
      "f": return 'h444;
      "h": return 'h445;
      "x": return 'h445;
      "w": return 'h449;
      "y": return 'h44B;
      "q": return 'h44F;
      default: return NOT_LETTER;
    endcase
  endfunction

  function automatic bit takes_h(input logic [7:0] c);
    logic [7:0] f;
    f = c | 8'h20;
    return c >= "A" && c <= "z" && (f == "c" || f == "s" || f == "e" || f == "k" || f == "z");
  endfunction

  function automatic int h_pair(input logic [7:0] c, input bit with_h);
    logic [7:0] f;
    int         v;
    f = c | 8'h20;
    case (f)
      "c": v = with_h ? 'h447 : 'h446;
      "s": v = with_h ? 'h448 : 'h441;
      "e": v = with_h ? 'h44D : 'h435;
      "k": v = with_h ? 'h445 : 'h43A;
      "z": v = with_h ? 'h436 : 'h437;
      default: return c;
    endcase
    return is_caps(c) ? v - 'h20 : v;
  endfunction

  function automatic int j_first(input logic [7:0] prev);
    return (prev == "J") ? 'h419 : 'h439;
  endfunction

  function automatic int j_pair(input logic [7:0] c, input bit caps);
    case (c)
      "A": return 'h42F;
      "O": return 'h401;
      "U": return 'h42E;
      "H": return 'h419;
      "a": return caps ? 'h42F : 'h44F;
      "o": return caps ? 'h401 : 'h451;
      "u": return caps ? 'h42E : 'h44E;
      "h": return caps ? 'h419 : 'h439;
      CH_APOS: return 'h42C;
      CH_GRAVE: return 'h42A;
      default: return NOT_LETTER;
    endcase
  endfunction

  function automatic void flush_held();
    if (tl_pend == PEND_H) put_code(h_pair(tl_prev, 1'b0));
    else if (tl_pend == PEND_J) put_code(j_first(tl_prev));
    tl_pend = PEND_NONE;
  endfunction

  function automatic void normal_char(input logic [7:0] c);
    int lw;
    int r;
    r = NOT_LETTER;
    if (tl_pend == PEND_J) begin
      r = j_pair(c, tl_prev == "J");
      if (r == NOT_LETTER) put_code(j_first(tl_prev));
    end else if (tl_pend == PEND_H) begin
      if (c == "h" || c == "H") r = h_pair(tl_prev, 1'b1);
      else put_code(h_pair(tl_prev, 1'b0));
    end
    tl_pend = PEND_NONE;
    if (r == NOT_LETTER) begin
      lw = plain_letter(c | 8'h20);
      if (c == CH_APOS) r = 'h44C;
      else if (c == CH_GRAVE) r = 'h44A;
      else if (c == "j" || c == "J") tl_pend = PEND_J;
      else if (takes_h(c)) tl_pend = PEND_H;
      else if (c >= "A" && c <= "z" && lw != NOT_LETTER) r = is_caps(c) ? lw - 'h20 : lw;
      else r = c;
    end
    if (r != NOT_LETTER) put_code(r);
  endfunction

  // works out the output bytes of one request and queues them
  function automatic void transliterate(input logic kind, input logic [7:0] c);
    bit        again;
    out_beat_t beat;
    req_bytes.delete();
    if (kind == REQ_FLUSH) begin
      if (tl_mode == MODE_NORMAL) flush_held();
      else if (tl_mode == MODE_AFTER1) put_byte(SWITCH_BYTE);
      tl_mode     = MODE_NORMAL;
      tl_pend     = PEND_NONE;
      tl_ret_verb = 1'b0;
      tl_prev     = 8'h00;
    end else begin
      again = 1'b1;
      while (again) begin
        again = 1'b0;
        case (tl_mode)
          MODE_NORMAL: begin
            // the enable only matters here, open spans run to their end
            if (tl_esc && c == SWITCH_BYTE) begin
              flush_held();
              tl_ret_verb = 1'b0;
              tl_mode = MODE_AFTER1;
            end else normal_char(c);
          end
          MODE_VERBATIM: begin
            if (c == SWITCH_BYTE) begin
              tl_ret_verb = 1'b1;
              tl_mode = MODE_AFTER1;
            end else put_byte(c);
          end
          MODE_AFTER1: begin
            if (c == SWITCH_BYTE) tl_mode = MODE_AFTER2;
            else begin
              put_byte(SWITCH_BYTE);
              tl_mode = tl_ret_verb ? MODE_VERBATIM : MODE_NORMAL;
              tl_ret_verb = 1'b0;
              again = 1'b1;
            end
          end
          default: begin
            if (c != SWITCH_BYTE) begin
              // ";;" toggles the span, then the byte is handled in the new mode
              tl_mode = tl_ret_verb ? MODE_NORMAL : MODE_VERBATIM;
              tl_ret_verb = 1'b0;
              again = 1'b1;
            end else begin
              put_byte(SWITCH_BYTE);
              put_byte(SWITCH_BYTE);
              tl_mode = tl_ret_verb ? MODE_VERBATIM : MODE_NORMAL;
              tl_ret_verb = 1'b0;
            end
          end
        endcase
      end
      tl_prev = c;
    end
    foreach (req_bytes[i]) begin
      beat.b    = req_bytes[i];
      beat.last = (i == req_bytes.size() - 1);
      cyr_bytes_q.push_back(beat);
    end
  endfunction

  // ---------------------------------------------------------------- bus side

  task automatic send_req(input logic kind, input logic [7:0] data);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
    transliterate(kind, data);
    n_reqs++;
    if (kind == REQ_FLUSH) n_flushes++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_req(REQ_BYTE, s[i]);
  endtask

  // waits for all expected output bytes to drain before registers change
  task automatic settle();
    in_tvalid <= 1'b0;
    while (cyr_bytes_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (idx == REG_ESCAPES) tl_esc = value[0];
    else tl_enc = value[1:0];
  endtask

  function automatic logic [7:0] text_byte();
    int s;
    int v;
    s = $urandom_range(0, 99);
    if (s < 55) return letter_pool[$urandom_range(0, letter_pool.len() - 1)];
    if (s < 70) begin
      v = $urandom_range(0, 3);
      return (v == 0) ? "h" : (v == 1) ? "H" : (v == 2) ? "j" : "J";
    end
    if (s < 78) return ($urandom_range(0, 1) != 0) ? CH_APOS : CH_GRAVE;
    v = (s < 90) ? $urandom_range(0, 127) : $urandom_range(0, 255);
    return v[7:0];
  endfunction

  // receiver: after each accepted byte hold ready low for a drawn stall
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      if (stall_left == 1) out_tready <= 1'b1;
    end else if (out_tvalid && out_tready) begin
      stall_draw = no_idle ? 0 : $urandom_range(0, 6);
      if (stall_draw > 0) begin
        out_tready <= 1'b0;
        stall_left <= stall_draw;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      n_beats++;
      if (cyr_bytes_q.size() == 0) begin
        if (n_errs < 10)
          $display("unexpected output byte %02h last %0b, nothing pending", out_tdata, out_tlast);
        n_errs++;
      end else begin
        head_beat = cyr_bytes_q.pop_front();
        if (out_tdata !== head_beat.b || out_tlast !== head_beat.last) begin
          if (n_errs < 10)
            $display("mismatch at byte %0d: expected %02h last %0b, got %02h last %0b",
                     n_beats, head_beat.b, head_beat.last, out_tdata, out_tlast);
          n_errs++;
        end
      end
    end
  end

  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles == CYCLE_LIMIT) begin
      $display("timeout with %0d bytes still pending", cyr_bytes_q.size());
      $display("latin_to_cyrillic_transliterator_tb: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests

  // reset defaults: koi8-r, no escapes; digraphs, byte extremes, held letter flush
  task automatic test_koi8_digraphs();
    send_text("JojhCh");
    send_req(REQ_BYTE, 8'h00);
    send_req(REQ_BYTE, 8'hFF);
    send_text("k");
    send_req(REQ_FLUSH, 8'hFF);
  endtask

  // verbatim span, literal pair inside it, ";;" dropped and lone ';' sent on flush
  task automatic test_utf8_escapes();
    settle();
    write_reg(REG_ESCAPES, 32'd1);
    write_reg(REG_ENCODING, {30'd0, ENC_UTF8});
    send_text(";;a;;;;;");
    send_req(REQ_FLUSH, 8'h00);
    send_text("J;");
    send_req(REQ_FLUSH, 8'h00);
  endtask

  // escapes switched off inside a span, then the unused encoding
  task automatic test_iso_spare_midspan();
    settle();
    write_reg(REG_ENCODING, {30'd0, ENC_ISO});
    send_text("q;;");
    settle();
    write_reg(REG_ESCAPES, 32'd0);
    write_reg(REG_ENCODING, {30'd0, ENC_SPARE});
    send_text("w;;w");
  endtask

  task automatic test_random_text();
    int sent;
    int r;
    int run;
    for (int p = 0; p < 6; p++) begin
      settle();
      write_reg(REG_ESCAPES, {31'd0, p[0] ^ p[2]});
      write_reg(REG_ENCODING, {30'd0, p[1:0]});
      no_idle = (p == 2 || p == 5);
      sent = 0;
      while (sent < PHASE_REQS) begin
        r = $urandom_range(0, 99);
        if (r < 4) begin
          send_req(REQ_FLUSH, text_byte());
          sent++;
        end else if (r < 18) begin
          // semicolon runs of one to three reach every escape state
          run = $urandom_range(1, 3);
          repeat (run) send_req(REQ_BYTE, SWITCH_BYTE);
          sent += run;
        end else begin
          send_req(REQ_BYTE, text_byte());
          sent++;
        end
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    tl_mode     = MODE_NORMAL;
    tl_pend     = PEND_NONE;
    tl_ret_verb = 1'b0;
    tl_prev     = 8'h00;
    tl_esc      = 1'b0;
    tl_enc      = ENC_RESET;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_koi8_digraphs();
    test_utf8_escapes();
    test_iso_spare_midspan();
    test_random_text();
    settle();
    $display("sent %0d requests (%0d end-of-stream flushes), checked %0d output bytes",
             n_reqs, n_flushes, n_beats);
    $display("all four encodings, escapes on and off, idle and back-to-back phases");
    if (n_errs == 0 && cyr_bytes_q.size() == 0) begin
      $display("latin_to_cyrillic_transliterator_tb: done, clean");
    end else begin
      $display("%0d mismatches, %0d bytes never seen", n_errs, cyr_bytes_q.size());
      $display("latin_to_cyrillic_transliterator_tb: done, errors");
    end
    $finish;
  end

endmodule
